>>> hdl/hiq_pkg.sv
`default_nettype none
package hiq_pkg;

    // default sizes
    localparam int REF_DEPTH_DEF  = 1048576;
    localparam int MAX_OP_LEN_DEF = 64;

    // fixed field widths
    localparam int BASE_W  = 8;
    localparam int POS_W   = 20;
    localparam int CODE_W  = 4;
    localparam int OPLEN_W = 7;
    localparam int CUR_W   = 21;
    localparam int RUN_W   = 5;
    localparam int QUAL_W  = 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;

    localparam logic [RUN_W-1:0]  RUN_SAT    = 5'd19;
    localparam logic [RUN_W-1:0]  QMAX_COUNT = 5'd18;
    localparam logic [QUAL_W-1:0] QUAL_BANG  = 7'd33;

    // action selector carried on s_tuser
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_OP    = 2'd2;

    // alignment operation codes
    localparam logic [CODE_W-1:0] OP_MATCH = 4'd0;
    localparam logic [CODE_W-1:0] OP_INS   = 4'd1;
    localparam logic [CODE_W-1:0] OP_DEL   = 4'd2;
    localparam logic [CODE_W-1:0] OP_SOFT  = 4'd4;
    localparam logic [CODE_W-1:0] OP_HARD  = 4'd5;
    localparam logic [CODE_W-1:0] OP_EQUAL = 4'd7;
    localparam logic [CODE_W-1:0] OP_DIFF  = 4'd8;

    localparam int QDEPTH = 2;
    localparam int QCNT_W = 2;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_START  = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_BANG   = 3'd3,
        CMD_SKIP   = 3'd4,
        CMD_BAD    = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [BASE_W-1:0]    base;
        logic                 fresh;
        logic [POS_W-1:0]     pos;
        logic [OPLEN_W-1:0]   len;
    } cmd_t;

    // run count -> quality character
    function automatic logic [QUAL_W-1:0] qual_of(input logic [RUN_W-1:0] c);
        logic [QUAL_W-1:0] q;
        q = QUAL_BANG;
        unique case (c)
            5'd0:    q = 7'd33;
            5'd1:    q = 7'd77;
            5'd2:    q = 7'd77;
            5'd3:    q = 7'd77;
            5'd4:    q = 7'd76;
            5'd5:    q = 7'd75;
            5'd6:    q = 7'd69;
            5'd7:    q = 7'd67;
            5'd8:    q = 7'd64;
            5'd9:    q = 7'd61;
            5'd10:   q = 7'd60;
            5'd11:   q = 7'd59;
            5'd12:   q = 7'd58;
            5'd13:   q = 7'd57;
            5'd14:   q = 7'd56;
            5'd15:   q = 7'd56;
            5'd16:   q = 7'd55;
            5'd17:   q = 7'd55;
            5'd18:   q = 7'd54;
            default: q = QUAL_BANG;
        endcase
        return q;
    endfunction

endpackage
`default_nettype wire

>>> hdl/hiq_ram.sv
`default_nettype none
module hiq_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hdl/hiq_cmd_fifo.sv
`default_nettype none
module hiq_cmd_fifo
    import hiq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire cmd_t              push_cmd,
    input  wire logic              pop,
    output cmd_t                   head,
    output logic                   empty,
    output logic                   full,
    output logic [QCNT_W-1:0]      count
);

    cmd_t             slot_reg [QDEPTH];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign count   = cnt_reg;
    assign head    = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wptr_next = do_push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> hdl/hiq_front.sv
`default_nettype none
module hiq_front
    import hiq_pkg::*;
#(
    parameter int MAX_OP_LEN = MAX_OP_LEN_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cmd_t                      q_cmd
);

    localparam logic [OPLEN_W-1:0] MAX_LEN = OPLEN_W'(MAX_OP_LEN);

    logic                active_reg, active_next;
    logic                accept;
    logic [CODE_W-1:0]   code;
    logic [OPLEN_W-1:0]  raw_len, len_c;
    logic                len_nz;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign code     = s_tdata[33:30];
    assign raw_len  = s_tdata[40:34];
    assign len_c    = (raw_len > MAX_LEN) ? MAX_LEN : raw_len;
    assign len_nz   = (len_c != '0);

    always_comb begin
        q_cmd.kind  = CMD_LOAD;
        q_cmd.base  = s_tdata[7:0];
        q_cmd.fresh = s_tdata[8];
        q_cmd.pos   = s_tdata[28:9];
        q_cmd.len   = len_c;
        q_push      = 1'b0;
        active_next = active_reg;
        if (accept) begin
            unique case (s_tuser)
                ACT_LOAD: begin
                    q_push = 1'b1;
                end
                ACT_START: begin
                    q_cmd.kind  = CMD_START;
                    q_push      = 1'b1;
                    active_next = s_tdata[29];
                end
                ACT_OP: begin
                    if (active_reg) begin
                        unique case (code)
                            OP_MATCH, OP_EQUAL, OP_DIFF: begin
                                q_cmd.kind = CMD_LOOKUP;
                                q_push     = len_nz;
                            end
                            OP_INS, OP_SOFT: begin
                                q_cmd.kind = CMD_BANG;
                                q_push     = len_nz;
                            end
                            OP_DEL: begin
                                q_cmd.kind = CMD_SKIP;
                                q_push     = len_nz;
                            end
                            OP_HARD: begin
                                q_push = 1'b0;
                            end
                            default: begin
                                // unsupported code: one flagged beat, read disarmed
                                q_cmd.kind  = CMD_BAD;
                                q_push      = 1'b1;
                                active_next = 1'b0;
                            end
                        endcase
                    end
                end
                default: begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
    end

endmodule
`default_nettype wire

>>> hdl/hiq_back.sv
`default_nettype none
module hiq_back
    import hiq_pkg::*;
#(
    parameter int REF_DEPTH = REF_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 q_head,
    input  wire logic                 q_empty,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast,
    output logic [0:0]                m_tuser
);

    localparam int ADDR_W = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int LEN_W  = $clog2(REF_DEPTH + 1);
    localparam int CMP_W  = ((LEN_W > CUR_W) ? LEN_W : CUR_W) + 1;
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(REF_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LOAD2 = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    typedef struct packed {
        logic [QUAL_W-1:0] qual;
        logic              last;
        logic              bad;
    } beat_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   ref_len_reg, ref_len_next;
    logic [ADDR_W-1:0]  run_start_reg, run_start_next;
    logic [RUN_W-1:0]   run_len_reg, run_len_next;
    logic [BASE_W-1:0]  run_sym_reg, run_sym_next;
    logic [CUR_W-1:0]   cursor_reg, cursor_next;
    logic [OPLEN_W-1:0] cnt_reg, cnt_next;
    logic               lookup_reg, lookup_next;
    logic               bad_reg, bad_next;

    logic               pend_valid_reg, pend_valid_next;
    logic               pend_bang_reg, pend_bang_next;
    logic               pend_last_reg, pend_last_next;
    logic               pend_bad_reg, pend_bad_next;

    beat_t              o0_reg, o0_next, o1_reg, o1_next;
    logic [1:0]         occ_reg, occ_next;

    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [RUN_W-1:0]   wr_data, rd_data;

    logic [LEN_W-1:0]   load_pos;
    logic               new_run;
    logic [CMP_W-1:0]   cur_ext, rlen_ext, cur_plus1;
    logic               out_range;
    logic               pop_out, push_out, issue;
    logic [1:0]         occ_eff;
    beat_t              land;

    hiq_ram #(
        .WIDTH (RUN_W),
        .DEPTH (REF_DEPTH)
    ) u_run_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cur_ext   = CMP_W'(cursor_reg);
    assign rlen_ext  = CMP_W'(ref_len_reg);
    assign cur_plus1 = cur_ext + CMP_W'(1);
    // lookup at cursor+1 is only legal while cursor+2 <= reference length
    assign out_range = (cur_ext + CMP_W'(2)) > rlen_ext;
    assign rd_addr   = cur_plus1[ADDR_W-1:0];

    assign load_pos  = q_head.fresh ? '0 : ref_len_reg;
    assign new_run   = (load_pos == '0) || (q_head.base != run_sym_reg);

    assign pop_out   = m_tvalid && m_tready;
    assign push_out  = pend_valid_reg;
    assign occ_eff   = occ_reg + {1'b0, pend_valid_reg} - {1'b0, pop_out};
    assign issue     = (state_reg == ST_EMIT) && (occ_eff <= 2'd1);
    assign rd_en     = issue && lookup_reg;

    assign land.qual = pend_bang_reg ? QUAL_BANG : qual_of(rd_data);
    assign land.last = pend_last_reg;
    assign land.bad  = pend_bad_reg;

    assign m_tvalid  = (occ_reg != 2'd0);
    assign m_tdata   = {1'b0, o0_reg.qual};
    assign m_tlast   = o0_reg.last;
    assign m_tuser   = o0_reg.bad;

    // command execution
    always_comb begin
        state_next     = state_reg;
        ref_len_next   = ref_len_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        run_sym_next   = run_sym_reg;
        cursor_next    = cursor_reg;
        cnt_next       = cnt_reg;
        lookup_next    = lookup_reg;
        bad_next       = bad_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = load_pos[ADDR_W-1:0];
        wr_data        = RUN_W'(1);
        pend_valid_next = issue;
        pend_bang_next  = !lookup_reg || out_range;
        pend_last_next  = (cnt_reg == OPLEN_W'(1));
        pend_bad_next   = bad_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    unique case (q_head.kind)
                        CMD_LOAD: begin
                            if (q_head.fresh) begin
                                ref_len_next = '0;
                            end
                            // table full: base dropped
                            if (load_pos != FULL_LEN) begin
                                wr_en        = 1'b1;
                                ref_len_next = load_pos + LEN_W'(1);
                                if (new_run) begin
                                    run_start_next = load_pos[ADDR_W-1:0];
                                    run_len_next   = RUN_W'(1);
                                    run_sym_next   = q_head.base;
                                end else begin
                                    run_len_next = (run_len_reg < RUN_SAT) ?
                                                   run_len_reg + RUN_W'(1) : RUN_SAT;
                                    state_next   = ST_LOAD2;
                                end
                            end
                        end
                        CMD_START: begin
                            cursor_next = CUR_W'(q_head.pos);
                        end
                        CMD_SKIP: begin
                            cursor_next = cursor_reg + CUR_W'(q_head.len);
                        end
                        CMD_LOOKUP: begin
                            cnt_next    = q_head.len;
                            lookup_next = 1'b1;
                            bad_next    = 1'b0;
                            state_next  = ST_EMIT;
                        end
                        CMD_BANG: begin
                            cnt_next    = q_head.len;
                            lookup_next = 1'b0;
                            bad_next    = 1'b0;
                            state_next  = ST_EMIT;
                        end
                        CMD_BAD: begin
                            cnt_next    = OPLEN_W'(1);
                            lookup_next = 1'b0;
                            bad_next    = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_LOAD2: begin
                // rewrite run head with the updated length
                wr_en      = 1'b1;
                wr_addr    = run_start_reg;
                wr_data    = run_len_reg;
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                if (issue) begin
                    cnt_next = cnt_reg - OPLEN_W'(1);
                    if (lookup_reg) begin
                        cursor_next = cursor_reg + CUR_W'(1);
                    end
                    if (cnt_reg == OPLEN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // two-entry output skid
    always_comb begin
        o0_next  = o0_reg;
        o1_next  = o1_reg;
        occ_next = occ_reg;
        unique case ({push_out, pop_out})
            2'b10: begin
                if (occ_reg == 2'd0) begin
                    o0_next = land;
                end else begin
                    o1_next = land;
                end
                occ_next = occ_reg + 2'd1;
            end
            2'b01: begin
                o0_next  = o1_reg;
                occ_next = occ_reg - 2'd1;
            end
            2'b11: begin
                if (occ_reg == 2'd1) begin
                    o0_next = land;
                end else begin
                    o0_next = o1_reg;
                    o1_next = land;
                end
            end
            default: begin
                occ_next = occ_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ref_len_reg    <= '0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            run_sym_reg    <= '0;
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
            occ_reg        <= 2'd0;
        end else begin
            state_reg      <= state_next;
            ref_len_reg    <= ref_len_next;
            run_start_reg  <= run_start_next;
            run_len_reg    <= run_len_next;
            run_sym_reg    <= run_sym_next;
            cursor_reg     <= cursor_next;
            pend_valid_reg <= pend_valid_next;
            occ_reg        <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        lookup_reg    <= lookup_next;
        bad_reg       <= bad_next;
        pend_bang_reg <= pend_bang_next;
        pend_last_reg <= pend_last_next;
        pend_bad_reg  <= pend_bad_next;
        o0_reg        <= o0_next;
        o1_reg        <= o1_next;
    end

endmodule
`default_nettype wire

>>> hdl/homopolymer_indel_quality.sv
// Homopolymer indel quality generator.
// Slave stream (s_*): one beat per item. s_tuser selects the action:
//   load reference base, start read, or alignment operation.
// Master stream (m_*): one beat per query base; m_tdata carries the quality
//   character, m_tlast marks the last beat caused by an input item, m_tuser
//   flags an unsupported operation code.
// Loads build a run-length table in a single-port-write RAM (one base per
//   beat, two RAM writes when the base extends a run). Reads look up that
//   table at cursor+1; insertions and soft clips give '!'.
// The back end takes one queued command at a time: an operation of n bases
//   is popped and then gives its n result beats (one table read per lookup
//   beat) before the next command is taken; a load that extends a run adds
//   the ST_LOAD2 rewrite, and read starts and deletions finish on the pop.
// A 2-entry command queue decouples the accepting front from the back end, so
//   s_tready stays high until that queue fills.
// Reset (aresetn low, synchronous) empties the queue, output stage and read
//   state; the table keeps no valid bits and needs no clearing pass.
// When m_tready is low the back end stops issuing reads once its 2-entry
//   output skid is committed; held beats are kept intact.
`default_nettype none
module homopolymer_indel_quality
    import hiq_pkg::*;
#(
    parameter int REF_DEPTH  = REF_DEPTH_DEF,
    parameter int MAX_OP_LEN = MAX_OP_LEN_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [7:0] base, [8] new_reference, [28:9] read_position, [29] proper_pair,
    // [33:30] cigar_code, [40:34] op_length, [47:41] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] action
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [6:0] quality_char, [7] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    // last
    output logic                      m_tlast,
    // [0] bad_opcode
    output logic [0:0]                m_tuser
);

    logic              q_push, q_pop, q_empty, q_full;
    cmd_t              q_cmd, q_head;
    logic [QCNT_W-1:0] q_count;

    // front: classify beats, track whether a read is armed
    hiq_front #(
        .MAX_OP_LEN (MAX_OP_LEN)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    hiq_cmd_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full),
        .count    (q_count)
    );

    // back: table build, cursor, result beats
    hiq_back #(
        .REF_DEPTH (REF_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // a flagged beat ends its item
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("bad opcode beat without tlast");

    // a flagged beat always carries the lowest quality
    a_bad_is_bang: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[QUAL_W-1:0] == QUAL_BANG)
        else $error("bad opcode beat with wrong quality");

    // queue never overfills, and the front stalls exactly when it is full
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count == QCNT_W'(QDEPTH) |-> !s_tready && !q_push)
        else $error("command queue overflow");

endmodule
`default_nettype wire

>>> tb/qual_check_pkg.sv
`timescale 1ns / 100ps
package qual_check_pkg;
    import hiq_pkg::*;

    localparam logic [1:0]        ACT_UNUSED     = 2'd3;
    localparam logic [CODE_W-1:0] OP_UNSUPPORTED = 4'd15;
    localparam int unsigned       RUN_CAP        = 19;
    localparam int unsigned       COUNT_TOP      = 18;
    localparam int unsigned       CURSOR_MASK    = (1 << CUR_W) - 1;

    typedef struct packed {
        logic [QUAL_W-1:0] qual;
        logic              is_last;
        logic              bad_code;
    } qual_beat_t;

    // Tracks the homopolymer table and read state, queues the quality beats due.
    class indel_qual_scoreboard;
        bit [RUN_W-1:0] homo_len [int unsigned];
        int unsigned    ref_len;
        int unsigned    run_pos;
        int unsigned    run_cnt;
        bit [7:0]       run_sym;
        int unsigned    cursor;
        bit             armed;
        string          qchars;
        int unsigned    beat_idx;
        qual_beat_t     due_quals [$];

        function new();
            qchars   = "!MMMLKEC@=<;:988776";
            ref_len  = 0;
            run_pos  = 0;
            run_cnt  = 0;
            run_sym  = 8'd0;
            cursor   = 0;
            armed    = 1'b0;
            beat_idx = 0;
        endfunction

        function int unsigned pending();
            return due_quals.size();
        endfunction

        function void note_item(logic [1:0] act, logic [S_TDATA_W-1:0] data);
            logic [BASE_W-1:0]  b;
            logic               fresh;
            logic [POS_W-1:0]   pos;
            logic               pp;
            logic [CODE_W-1:0]  code;
            int unsigned        len;
            int unsigned        n0;
            int unsigned        c;
            qual_beat_t         qb;
            b     = data[7:0];
            fresh = data[8];
            pos   = data[28:9];
            pp    = data[29];
            code  = data[33:30];
            len   = 32'(data[40:34]);
            n0    = due_quals.size();
            case (act)
                ACT_LOAD: begin
                    if (fresh)
                        ref_len = 0;
                    if (ref_len < REF_DEPTH_DEF) begin
                        homo_len[ref_len] = RUN_W'(1);
                        if (ref_len == 0 || b != run_sym) begin
                            run_pos = ref_len;
                            run_cnt = 1;
                            run_sym = b;
                        end else begin
                            if (run_cnt < RUN_CAP)
                                run_cnt++;
                            homo_len[run_pos] = run_cnt[RUN_W-1:0];
                        end
                        ref_len++;
                    end
                end
                ACT_START: begin
                    cursor = 32'(pos);
                    armed  = pp;
                end
                ACT_OP: begin
                    if (armed) begin
                        if (len > MAX_OP_LEN_DEF)
                            len = MAX_OP_LEN_DEF;
                        qb.is_last  = 1'b0;
                        qb.bad_code = 1'b0;
                        case (code)
                            OP_MATCH, OP_EQUAL, OP_DIFF: begin
                                for (int j = 0; j < len; j++) begin
                                    qb.qual = QUAL_W'(qchars[0]);
                                    // too close to the reference end: no lookup
                                    if (longint'(cursor) + 2 <= longint'(ref_len)) begin
                                        c = 32'(homo_len[cursor + 1]);
                                        if (c <= COUNT_TOP)
                                            qb.qual = QUAL_W'(qchars[c]);
                                    end
                                    due_quals.push_back(qb);
                                    cursor = (cursor + 1) & CURSOR_MASK;
                                end
                            end
                            OP_INS, OP_SOFT: begin
                                qb.qual = QUAL_W'(qchars[0]);
                                repeat (len) due_quals.push_back(qb);
                            end
                            OP_DEL: cursor = (cursor + len) & CURSOR_MASK;
                            OP_HARD: ;
                            default: begin
                                qb.qual     = QUAL_W'(qchars[0]);
                                qb.bad_code = 1'b1;
                                due_quals.push_back(qb);
                                armed = 1'b0;
                            end
                        endcase
                        if (due_quals.size() > n0)
                            due_quals[$].is_last = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        // returns an empty string when the beat matches
        function string check_beat(logic [M_TDATA_W-1:0] qbits, logic tlast,
                                   logic [0:0] flag);
            qual_beat_t want;
            string      why;
            why = "";
            beat_idx++;
            if (due_quals.size() == 0)
                return $sformatf("beat %0d unexpected: q=%0d last=%b bad=%b",
                                 beat_idx, qbits, tlast, flag);
            want = due_quals.pop_front();
            if (qbits !== {1'b0, want.qual})
                why = {why, $sformatf(" quality %0d want %0d", qbits, want.qual)};
            if (tlast !== want.is_last)
                why = {why, $sformatf(" last %b want %b", tlast, want.is_last)};
            if (flag[0] !== want.bad_code)
                why = {why, $sformatf(" bad_opcode %b want %b", flag, want.bad_code)};
            if (why != "")
                why = $sformatf("beat %0d:%s", beat_idx, why);
            return why;
        endfunction
    endclass

endpackage

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import hiq_pkg::*;
    import qual_check_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 7;
    localparam int TAIL_CYC    = 20;         // tail wait before the final pending check
    localparam int TIMEOUT_NS  = 20_000_000; // far above the length of a slow pass

    // clock / reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // input stream (one beat per item)
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = ACT_LOAD;

    // result stream (one beat per query base)
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;

    // idle rates in percent, changed per phase
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    int          items_sent = 0;  // ignored beats (unused action) not counted
    int          mismatches = 0;
    int unsigned ref_len_tb = 0;  // reference length as seen by the stimulus side
    string       nuc_set    = "ACGT";

    indel_qual_scoreboard sb = new();

    homopolymer_indel_quality u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // receiver back-pressure: one draw per cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // result monitor: values read here are the ones present at the edge
    always @(posedge aclk) begin : result_mon
        string why;
        if (aresetn && m_tvalid && m_tready) begin
            why = sb.check_beat(m_tdata, m_tlast, m_tuser);
            if (why != "")
                report_mismatch(why);
        end
    end

    task automatic report_mismatch(input string why);
        mismatches++;
        $display("[%0t] MISMATCH %s", $time, why);
    endtask

    // tdata layout: base, new_reference, read_position, proper_pair,
    // cigar_code, op_length, zero pad
    function automatic logic [S_TDATA_W-1:0] pack_fields(
        input logic [BASE_W-1:0]  b,
        input logic               fresh,
        input logic [POS_W-1:0]   pos,
        input logic               pp,
        input logic [CODE_W-1:0]  code,
        input logic [OPLEN_W-1:0] len
    );
        return {7'd0, len, code, pp, pos, fresh, b};
    endfunction

    // Drive one beat and hold it until accepted; random gaps in front of it.
    task automatic put_item(input logic [1:0] act, input logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_item(act, data);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    // Unused fields of each kind carry random junk; the block must ignore it.
    task automatic load_base(input logic [BASE_W-1:0] b, input logic fresh);
        if (fresh)
            ref_len_tb = 0;
        ref_len_tb++;
        put_item(ACT_LOAD, pack_fields(b, fresh, POS_W'($urandom), 1'($urandom),
                                       CODE_W'($urandom), OPLEN_W'($urandom)));
    endtask

    task automatic start_read(input logic [POS_W-1:0] pos, input logic pp);
        put_item(ACT_START, pack_fields(BASE_W'($urandom), 1'($urandom), pos, pp,
                                        CODE_W'($urandom), OPLEN_W'($urandom)));
    endtask

    task automatic align_op(input logic [CODE_W-1:0] code, input logic [OPLEN_W-1:0] len);
        put_item(ACT_OP, pack_fields(BASE_W'($urandom), 1'($urandom), POS_W'($urandom),
                                     1'($urandom), code, len));
    endtask

    // Stop sending and wait until every due beat has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // A reference built from runs; some runs are long enough to saturate the
    // count. Mostly a new reference, sometimes appended to the current one.
    task automatic random_reference();
        int          n_bases;
        int          run;
        int          cnt;
        logic        fresh;
        logic [7:0]  sym;
        n_bases = $urandom_range(8, 40);
        fresh   = ($urandom_range(99) < 85);
        cnt     = 0;
        while (cnt < n_bases) begin
            if ($urandom_range(19) == 0)
                sym = BASE_W'($urandom_range(255));
            else
                sym = nuc_set[$urandom_range(3)];
            if ($urandom_range(9) == 0)
                run = $urandom_range(15, 24);
            else
                run = $urandom_range(1, 4);
            repeat (run) begin
                load_base(sym, fresh);
                fresh = 1'b0;
                cnt++;
            end
        end
    endtask

    // Mostly well-formed reads (start + a few ops) over the current reference,
    // with noise: unused action, reads that are not properly paired.
    task automatic run_phase(input int src_pct, input int snk_pct, input int n_items);
        int                 stop_at;
        int                 pick;
        int                 r;
        logic [POS_W-1:0]   pos;
        logic [CODE_W-1:0]  code;
        logic [OPLEN_W-1:0] len;
        logic [S_TDATA_W-1:0] junk;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at      = items_sent + n_items;
        random_reference();
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                random_reference();
            end else if (pick < 11) begin
                junk = S_TDATA_W'({$urandom, $urandom});
                junk[S_TDATA_W-1:41] = '0;
                put_item(ACT_UNUSED, junk);
            end else if (pick < 14) begin
                start_read(POS_W'($urandom_range(0, ref_len_tb)), 1'b0);
                align_op(OP_MATCH, OPLEN_W'($urandom_range(1, 8)));
            end else begin
                if ($urandom_range(99) < 75)
                    pos = POS_W'($urandom_range(0, ref_len_tb + 2));
                else
                    pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
                start_read(pos, $urandom_range(99) < 92);
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(99);
                    if (r < 40)      code = OP_MATCH;
                    else if (r < 50) code = OP_EQUAL;
                    else if (r < 60) code = OP_DIFF;
                    else if (r < 70) code = OP_INS;
                    else if (r < 78) code = OP_SOFT;
                    else if (r < 86) code = OP_DEL;
                    else if (r < 93) code = OP_HARD;
                    else begin
                        do
                            code = CODE_W'($urandom_range(15));
                        while (code inside {OP_MATCH, OP_INS, OP_DEL, OP_SOFT,
                                            OP_HARD, OP_EQUAL, OP_DIFF});
                    end
                    r = $urandom_range(99);
                    if (r < 4)       len = '0;
                    else if (r < 10) len = OPLEN_W'($urandom_range(65, 127));  // clamped
                    else if (r < 25) len = OPLEN_W'($urandom_range(33, 64));
                    else             len = OPLEN_W'($urandom_range(1, 16));
                    align_op(code, len);
                end
            end
        end
        wait_drained();   // sender holds off until all due beats are out
    endtask

    initial begin
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        src_idle_pct = 7;
        snk_idle_pct = 45;
        // first base without new_reference: still opens a run
        load_base(8'h00, 1'b0);
        load_base(8'h00, 1'b0);
        repeat (4) load_base("C", 1'b0);
        load_base(8'hFF, 1'b0);
        load_base(8'hFF, 1'b0);
        load_base("T", 1'b0);
        start_read('0, 1'b1);
        align_op(OP_MATCH, 7'd5);
        align_op(OP_INS, 7'd1);
        align_op(OP_DEL, 7'd2);
        align_op(OP_SOFT, 7'd2);
        align_op(OP_HARD, 7'd3);
        align_op(OP_EQUAL, 7'd1);
        align_op(OP_DIFF, 7'd64);    // runs past the reference end
        align_op(OP_MATCH, 7'd0);    // no beats, cursor unchanged
        align_op(OP_MATCH, '1);      // over-long piece, clamped
        start_read(20'd3, 1'b0);     // not properly paired: ops dropped
        align_op(OP_MATCH, 7'd3);
        put_item(ACT_UNUSED, {7'd0, {41{1'b1}}});
        start_read('1, 1'b1);
        align_op(OP_UNSUPPORTED, 7'd1); // error beat, read disarmed
        align_op(OP_MATCH, 7'd2);    // dropped
        wait_drained();

        // random part: sender-light, receiver-heavy, swapped, then no idling
        run_phase(7, 45, 115);
        run_phase(45, 7, 115);
        run_phase(0, 0, 115);

        repeat (TAIL_CYC) @(posedge aclk);
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d beats never came out", sb.pending()));
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
